FILE: hdl/ssq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_pkg
// Shared constants and controller/datapath interface types for the sorted
// stack queue.
// ----------------------------------------------------------------------------
package ssq_pkg;

    // default number of stored entries
    localparam int DEPTH_DEF = 16;

    // data and field widths
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    // operation codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_POP    = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // result value of a pop on an empty store
    localparam logic [DATA_W-1:0] NEG_ONE = '1;

    // commands from controller to datapath
    typedef struct packed {
        logic load;       // capture request, start position at top
        logic rd;         // read entry below current position
        logic shift;      // move read entry up one slot, step position down
        logic place;      // write new value at current position
        logic pop_take;   // return read entry, drop top
        logic set_empty;  // report pop on empty store
        logic set_full;   // report rejected insert
        logic out_load;   // move result into output register
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic func_pop;   // captured request is a pop
        logic empty;      // no entries stored
        logic full;       // store at capacity
        logic pos_zero;   // position reached the bottom
        logic data_gt;    // read entry greater than new value
        logic out_free;   // output register can take a result
    } t_dp_stat;

endpackage

FILE: hdl/ssq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_ram
// Generic memory with one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module ssq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write, and registered read that holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/ssq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_ctrl
// Controller: sequences one request at a time through the entry walk and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module ssq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_in_ready,
    input  ssq_pkg::t_dp_stat i_stat,
    output ssq_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_CMP  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                if (i_stat.func_pop) begin
                    if (i_stat.empty) begin
                        o_cmd.set_empty = 1'b1;
                        n_state         = S_DONE;
                    end else begin
                        o_cmd.rd = 1'b1;
                        n_state  = S_CMP;
                    end
                end else if (i_stat.full) begin
                    o_cmd.set_full = 1'b1;
                    n_state        = S_DONE;
                end else if (i_stat.pos_zero) begin
                    o_cmd.place = 1'b1;
                    n_state     = S_DONE;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_CMP;
                end
            end
            S_CMP: begin
                if (i_stat.func_pop) begin
                    o_cmd.pop_take = 1'b1;
                    n_state        = S_DONE;
                end else if (i_stat.data_gt) begin
                    o_cmd.shift = 1'b1;
                    n_state     = S_READ;
                end else begin
                    o_cmd.place = 1'b1;
                    n_state     = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // a walk step always follows a read issued the cycle before
    a_cmp_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> $past(o_cmd.rd))
        else $error("compare state entered without a read");

    // a result is only loaded once the request has been resolved
    a_done_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_DONE) |-> $past(o_cmd.place || o_cmd.pop_take
            || o_cmd.set_empty || o_cmd.set_full))
        else $error("done state entered without a resolved result");

    // a new request is only taken when the previous result has been handed off
    a_load_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (r_state == S_IDLE) && !$past(r_state == S_READ)
            && !$past(r_state == S_CMP))
        else $error("request taken while another is in progress");

endmodule

FILE: hdl/ssq_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_dpath
// Datapath: entry memory, count, walk position, compare and output register.
// ----------------------------------------------------------------------------
module ssq_dpath #(
    parameter int DEPTH = ssq_pkg::DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ssq_pkg::t_dp_cmd             i_cmd,
    output ssq_pkg::t_dp_stat            o_stat,
    input  logic                         i_func,
    input  logic [ssq_pkg::DATA_W-1:0]   i_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [ssq_pkg::DATA_W-1:0]   o_result_value,
    output logic [ssq_pkg::STAT_W-1:0]   o_status,
    output logic [ssq_pkg::COUNT_W-1:0]  o_entry_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    // request and walk state
    logic                        r_func;
    logic [ssq_pkg::DATA_W-1:0]  r_value;
    logic [CW-1:0]               r_pos;
    logic [CW-1:0]               r_count;
    logic [ssq_pkg::DATA_W-1:0]  r_res;
    logic [ssq_pkg::STAT_W-1:0]  r_st;

    // output register
    logic                        r_o_valid;
    logic [ssq_pkg::DATA_W-1:0]  r_o_value;
    logic [ssq_pkg::STAT_W-1:0]  r_o_status;
    logic [CW-1:0]               r_o_count;

    // memory ports
    logic                        w_we;
    logic [AW-1:0]               w_waddr;
    logic [ssq_pkg::DATA_W-1:0]  w_wdata;
    logic [AW-1:0]               w_raddr;
    logic [ssq_pkg::DATA_W-1:0]  w_rdata;
    logic [CW-1:0]               w_pos_dn;
    logic [CW+ssq_pkg::COUNT_W-1:0] w_cnt_ext;

    // address the entry just below the position, write at the position
    assign w_pos_dn = r_pos - CW'(1);
    assign w_raddr  = w_pos_dn[AW-1:0];
    assign w_waddr  = r_pos[AW-1:0];
    assign w_we     = i_cmd.shift | i_cmd.place;
    assign w_wdata  = i_cmd.shift ? w_rdata : r_value;

    ssq_ram #(
        .WIDTH (ssq_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // status back to the controller
    assign o_stat.func_pop = (r_func == ssq_pkg::FUNC_POP);
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.full     = (r_count == FULL_CNT);
    assign o_stat.pos_zero = (r_pos == '0);
    assign o_stat.data_gt  = ($signed(w_rdata) > $signed(r_value));
    assign o_stat.out_free = !r_o_valid || i_ready;

    // capture request and hold result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_value <= i_value;
            r_pos   <= r_count;
        end else if (i_cmd.shift) begin
            r_pos <= w_pos_dn;
        end
        if (i_cmd.place) begin
            r_res <= '0;
            r_st  <= ssq_pkg::ST_OK;
        end
        if (i_cmd.pop_take) begin
            r_res <= w_rdata;
            r_st  <= ssq_pkg::ST_OK;
        end
        if (i_cmd.set_empty) begin
            r_res <= ssq_pkg::NEG_ONE;
            r_st  <= ssq_pkg::ST_EMPTY;
        end
        if (i_cmd.set_full) begin
            r_res <= '0;
            r_st  <= ssq_pkg::ST_FULL;
        end
        if (i_cmd.out_load) begin
            r_o_value  <= r_res;
            r_o_status <= r_st;
            r_o_count  <= r_count;
        end
    end

    // entry count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.place) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.pop_take) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // count field wraps to its width
    assign w_cnt_ext      = {{ssq_pkg::COUNT_W{1'b0}}, r_o_count};
    assign o_valid        = r_o_valid;
    assign o_result_value = r_o_value;
    assign o_status       = r_o_status;
    assign o_entry_count  = w_cnt_ext[ssq_pkg::COUNT_W-1:0];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count above capacity");

    a_shift_above_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.shift |-> (r_pos != '0) && (r_pos <= r_count))
        else $error("entry move outside stored range");

    a_place_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.place |-> (r_count != FULL_CNT) && (r_func == ssq_pkg::FUNC_INSERT))
        else $error("value written into full store or on pop");

    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !i_ready) |=> $stable(r_o_value) && $stable(r_o_status))
        else $error("pending result overwritten");

endmodule

FILE: hdl/sorted_stack_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_stack_queue_core
// Bounded max-priority queue over signed 32-bit values, kept as a sorted stack.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_ready): i_func selects a sorted insert of i_value
// or a pop of the largest entry. Output channel (o_valid / i_ready): one
// result per request with o_result_value, o_status and o_entry_count, the
// count after the operation.
// One request is in flight at a time. A pop on an empty store or an insert
// into a full store is resolved without a memory read; a pop reads the top
// entry and returns it. An insert walks down from the top of the store
// through the single read port of the entry memory, with its registered
// read: each step reads the entry below the position and moves it up one
// slot if it is larger, and the walk ends by writing the value above the
// first entry that is not larger, or at the bottom of the store. Each moved
// entry takes a read step and a compare/write step. The next request is
// taken once the previous result has entered the output register, so a
// finished result may wait there while the next request is being worked.
// If the receiver stalls, the result holds and the block stops after
// finishing the following request, until the output transfer.
// Reset empties the store at once (count to zero, no clearing pass) and drops
// any pending result.
// ----------------------------------------------------------------------------
module sorted_stack_queue_core #(
    parameter int DEPTH = ssq_pkg::DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_func,
    input  logic [ssq_pkg::DATA_W-1:0]   i_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [ssq_pkg::DATA_W-1:0]   o_result_value,
    output logic [ssq_pkg::STAT_W-1:0]   o_status,
    output logic [ssq_pkg::COUNT_W-1:0]  o_entry_count
);

    ssq_pkg::t_dp_cmd  w_cmd;
    ssq_pkg::t_dp_stat w_stat;

    // sequence the request
    ssq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_in_ready (o_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // store, walk and output register
    ssq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_func         (i_func),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_result_value (o_result_value),
        .o_status       (o_status),
        .o_entry_count  (o_entry_count)
    );

endmodule

FILE: tb/sorted_stack_queue_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_stack_queue_core_test
// Self-checking bench for the sorted stack queue. A short table of requests
// covers the signed extremes, equal values, a pop on an empty store and an
// insert into a full store. Random bursts of inserts and pops follow, some
// leaning toward filling or draining the store. Each result is checked against
// its table row or a behavioral copy, under three idle patterns on the channels.
// ----------------------------------------------------------------------------
module sorted_stack_queue_core_test;

    localparam int DEPTH      = ssq_pkg::DEPTH_DEF;
    localparam int QUIET_MAX  = 2000;  // cycles without any transfer
    localparam int DRAIN_WAIT = 40;
    localparam int BURSTS     = 25;    // per idle phase
    localparam int BURST_LEN  = 16;

    typedef struct packed {
        logic [ssq_pkg::DATA_W-1:0]  value;
        logic [ssq_pkg::STAT_W-1:0]  status;
        logic [ssq_pkg::COUNT_W-1:0] count;
    } t_result;

    typedef struct packed {
        logic                       func;
        logic [ssq_pkg::DATA_W-1:0] value;
        logic                       typed;   // use the result given in the row
        t_result                    want;
    } t_req_row;

    typedef struct packed {
        logic    typed;
        t_result want;
    } t_row_answer;

    // Directed requests; fixed results only where they are obvious
    localparam t_req_row PLAN [25] = '{
        '{ssq_pkg::FUNC_POP,    32'h0000_0000, 1'b1,
          '{ssq_pkg::NEG_ONE,   ssq_pkg::ST_EMPTY, 5'd0}},
        '{ssq_pkg::FUNC_INSERT, 32'h7FFF_FFFF, 1'b1, '{32'h0, ssq_pkg::ST_OK, 5'd1}},
        '{ssq_pkg::FUNC_INSERT, 32'h8000_0000, 1'b1, '{32'h0, ssq_pkg::ST_OK, 5'd2}},
        '{ssq_pkg::FUNC_INSERT, 32'h0000_0000, 1'b1, '{32'h0, ssq_pkg::ST_OK, 5'd3}},
        '{ssq_pkg::FUNC_INSERT, 32'hFFFF_FFFF, 1'b1, '{32'h0, ssq_pkg::ST_OK, 5'd4}},
        '{ssq_pkg::FUNC_INSERT, 32'h0000_0005, 1'b1, '{32'h0, ssq_pkg::ST_OK, 5'd5}},
        // equal value goes above its twin
        '{ssq_pkg::FUNC_INSERT, 32'h0000_0005, 1'b1, '{32'h0, ssq_pkg::ST_OK, 5'd6}},
        '{ssq_pkg::FUNC_POP,    32'h0000_0000, 1'b1,
          '{32'h7FFF_FFFF,      ssq_pkg::ST_OK, 5'd5}},
        '{ssq_pkg::FUNC_POP,    32'h0000_0000, 1'b0, '{32'h0, ssq_pkg::ST_OK, 5'd0}},
        '{ssq_pkg::FUNC_POP,    32'hFFFF_FFFF, 1'b0, '{32'h0, ssq_pkg::ST_OK, 5'd0}},
        '{ssq_pkg::FUNC_INSERT, 32'h5555_5555, 1'b0, '{32'h0, ssq_pkg::ST_OK, 5'd0}},
        '{ssq_pkg::FUNC_INSERT, 32'hAAAA_AAAA, 1'b0, '{32'h0, ssq_pkg::ST_OK, 5'd0}},
        '{ssq_pkg::FUNC_INSERT, 32'h7FFF_FFFE, 1'b0, '{32'h0, ssq_pkg::ST_OK, 5'd0}},
        '{ssq_pkg::FUNC_INSERT, 32'h8000_0001, 1'b0, '{32'h0, ssq_pkg::ST_OK, 5'd0}},
        '{ssq_pkg::FUNC_INSERT, 32'h0000_0001, 1'b0, '{32'h0, ssq_pkg::ST_OK, 5'd0}},
        '{ssq_pkg::FUNC_INSERT, 32'hFFFF_FFFE, 1'b0, '{32'h0, ssq_pkg::ST_OK, 5'd0}},
        '{ssq_pkg::FUNC_INSERT, 32'h1234_5678, 1'b0, '{32'h0, ssq_pkg::ST_OK, 5'd0}},
        '{ssq_pkg::FUNC_INSERT, 32'hEDCB_A987, 1'b0, '{32'h0, ssq_pkg::ST_OK, 5'd0}},
        '{ssq_pkg::FUNC_INSERT, 32'h0000_0000, 1'b0, '{32'h0, ssq_pkg::ST_OK, 5'd0}},
        '{ssq_pkg::FUNC_INSERT, 32'h0000_0000, 1'b0, '{32'h0, ssq_pkg::ST_OK, 5'd0}},
        '{ssq_pkg::FUNC_INSERT, 32'h7FFF_FFFF, 1'b0, '{32'h0, ssq_pkg::ST_OK, 5'd0}},
        '{ssq_pkg::FUNC_INSERT, 32'h8000_0000, 1'b0, '{32'h0, ssq_pkg::ST_OK, 5'd0}},
        '{ssq_pkg::FUNC_INSERT, 32'h0000_0003, 1'b1, '{32'h0, ssq_pkg::ST_OK, 5'd16}},
        // store is full now: drop the value
        '{ssq_pkg::FUNC_INSERT, 32'h7FFF_FFFF, 1'b1,
          '{32'h0,              ssq_pkg::ST_FULL, 5'd16}},
        '{ssq_pkg::FUNC_POP,    32'hFFFF_FFFF, 1'b1,
          '{32'h7FFF_FFFF,      ssq_pkg::ST_OK, 5'd15}}
    };

    logic                        i_clk   = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        i_func  = ssq_pkg::FUNC_INSERT;
    logic [ssq_pkg::DATA_W-1:0]  i_value = '0;
    logic                        i_ready = 1'b0;
    logic                        o_ready;
    logic                        o_valid;
    logic [ssq_pkg::DATA_W-1:0]  o_result_value;
    logic [ssq_pkg::STAT_W-1:0]  o_status;
    logic [ssq_pkg::COUNT_W-1:0] o_entry_count;

    // bench copy of the store, bottom (smallest) first
    logic [ssq_pkg::DATA_W-1:0] stack_model [$];
    t_row_answer                row_answers [$];
    t_result                    pending_results [$];

    t_row_answer answer;
    t_result     predicted;
    t_result     oldest;
    int          send_idle_pct = 31;
    int          recv_idle_pct = 53;
    int          errors = 0;
    int          quiet = 0;

    sorted_stack_queue_core #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_result_value (o_result_value),
        .o_status       (o_status),
        .o_entry_count  (o_entry_count)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Apply one request to the bench store and return its result
    function automatic t_result apply_request(logic func,
                                              logic [ssq_pkg::DATA_W-1:0] val);
        t_result r;
        int      pos;
        r.value  = '0;
        r.status = ssq_pkg::ST_OK;
        if (func == ssq_pkg::FUNC_INSERT) begin
            if (stack_model.size() >= DEPTH) begin
                r.status = ssq_pkg::ST_FULL;
            end else begin
                pos = 0;
                while (pos < stack_model.size() &&
                       $signed(stack_model[pos]) <= $signed(val)) pos++;
                stack_model.insert(pos, val);
            end
        end else if (stack_model.size() == 0) begin
            r.value  = ssq_pkg::NEG_ONE;
            r.status = ssq_pkg::ST_EMPTY;
        end else begin
            r.value = stack_model.pop_back();
        end
        r.count = ssq_pkg::COUNT_W'(stack_model.size());
        return r;
    endfunction

    // Mix narrow ranges (many equal values) with extremes and full-range values
    function automatic logic [ssq_pkg::DATA_W-1:0] pick_value();
        logic [ssq_pkg::DATA_W-1:0] v;
        case ($urandom_range(0, 4))
            0: v = ssq_pkg::DATA_W'($urandom_range(0, 7)) - ssq_pkg::DATA_W'(4);
            1: case ($urandom_range(0, 3))
                   0: v = 32'h7FFF_FFFF;
                   1: v = 32'h8000_0000;
                   2: v = 32'h0000_0000;
                   default: v = 32'hFFFF_FFFF;
               endcase
            2: v = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'($urandom_range(0, 3))}
                   ^ 32'h7FFF_FFFF;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic flag_mismatch(string what, logic [ssq_pkg::DATA_W-1:0] got,
                                 logic [ssq_pkg::DATA_W-1:0] want);
        $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
        errors++;
    endtask

    // Hold the request until its transfer; idle with valid low in between
    task automatic send_request(logic func, logic [ssq_pkg::DATA_W-1:0] val,
                                logic typed, t_result want);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        row_answers.push_back(t_row_answer'{typed, want});
        i_valid <= 1'b1;
        i_func  <= func;
        i_value <= val;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Receiver stalls at random
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Predict on each request transfer, check each result transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                answer    = row_answers.pop_front();
                predicted = apply_request(i_func, i_value);
                pending_results.push_back(answer.typed ? answer.want : predicted);
            end
            if (o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    flag_mismatch("result with no request", o_result_value, '0);
                end else begin
                    oldest = pending_results.pop_front();
                    if (o_result_value !== oldest.value)
                        flag_mismatch("result_value", o_result_value, oldest.value);
                    if (o_status !== oldest.status)
                        flag_mismatch("status", 32'(o_status), 32'(oldest.status));
                    if (o_entry_count !== oldest.count)
                        flag_mismatch("entry_count", 32'(o_entry_count),
                                      32'(oldest.count));
                end
            end
        end
    end

    // End the run when neither channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_MAX) begin
            $display("%0t: timeout, no transfer for %0d cycles", $time, quiet);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        int      pop_pct;
        t_result none;
        none = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (PLAN[k]) begin
            send_request(PLAN[k].func, PLAN[k].value, PLAN[k].typed, PLAN[k].want);
        end

        // random bursts: fill-heavy, drain-heavy or even, in three idle phases
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 31; recv_idle_pct = 53; end
                1: begin send_idle_pct = 53; recv_idle_pct = 31; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int b = 0; b < BURSTS; b++) begin
                case ($urandom_range(0, 2))
                    0: pop_pct = 15;
                    1: pop_pct = 85;
                    default: pop_pct = 50;
                endcase
                for (int n = 0; n < BURST_LEN; n++) begin
                    send_request(($urandom_range(0, 99) < pop_pct)
                                     ? ssq_pkg::FUNC_POP : ssq_pkg::FUNC_INSERT,
                                 pick_value(), 1'b0, none);
                end
            end
        end
        i_valid <= 1'b0;

        // drain outstanding results, then watch for strays
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
